@@ hw/rtl/rgbu_pkg.sv @@
package rgbu_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W  = COL_W + 1;
  localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int PIX_W   = 16;
  localparam int CFG_W   = 11;
  localparam int COORD_W = 11;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd200;

  // which destination column of the item is being issued
  typedef enum logic [2:0] {
    K_MID  = 3'b001,
    K_EVEN = 3'b010,
    K_EDGE = 3'b100
  } kind_t;

  // which destination row of the column is being emitted
  typedef enum logic [2:0] {
    PH_ABOVE = 3'b001,
    PH_EVEN  = 3'b010,
    PH_BELOW = 3'b100
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic [ROW_W-1:0]  row;
    logic [PIX_W-1:0]  pix;
    logic              first_row;
    logic              last_row;
    logic              item_last;
  } col_issue_t;

  // truncating per-channel average, flag bit cleared
  function automatic logic [PIX_W-1:0] avg555(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[14:10]} + {1'b0, b[14:10]};
    g  = {1'b0, a[9:5]}   + {1'b0, b[9:5]};
    bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
    return {1'b0, r[5:1], g[5:1], bl[5:1]};
  endfunction

endpackage

@@ hw/rtl/rgb555_upscale_2x_average.sv @@
// 2x upscaler for RGB555 pixels in raster order.
// Input channel: pixel_in with in_valid/in_ready, one source pixel per beat.
// Output channel: dest_x, dest_y, pixel_out, last_of_item with out_valid/out_ready,
// one destination pixel per beat; last_of_item marks the final beat of a source pixel.
// Configuration: cfg_write with cfg_index (0 source_width, 1 source_height) and
// cfg_data; a write restarts the frame at column 0, row 0. Write only while idle.
// Each source pixel gives 1 to 9 beats (4 in the frame interior). The output
// port delivers one beat per cycle while out_ready stays high; the first beat
// of an item passes the item stage, the emit stage and the output register.
// A source pixel splits into 1 to 3 destination columns; each column does one
// read-modify-write of the row store (one RAM port pair) and then yields up to
// three rows from an emit stage into the output register.
// Reset: clears counters and previous pixel, loads width 320 and height 200;
// the row store needs no clearing since every entry is written before use.
// When out_ready is low the output register holds, the emit stage and the item
// stage fill behind it, and in_ready drops once both hold work.
module rgb555_upscale_2x_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rgbu_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgbu_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgbu_pkg::PIX_W-1:0]    pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbu_pkg::COORD_W-1:0]  dest_x,
  output logic [rgbu_pkg::COORD_W-1:0]  dest_y,
  output logic [rgbu_pkg::PIX_W-1:0]    pixel_out,
  output logic                          last_of_item
);

  logic                       col_take;
  logic                       iss_valid;
  rgbu_pkg::col_issue_t       iss;
  logic [rgbu_pkg::PIX_W-1:0] rd_data;

  rgbu_feed u_feed (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .col_take  (col_take),
    .iss_valid (iss_valid),
    .iss       (iss)
  );

  // write the new even-row word and read the previous one in the same cycle
  rgbu_ram #(
    .WIDTH (rgbu_pkg::PIX_W),
    .DEPTH (rgbu_pkg::STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (iss_valid),
    .waddr (rgbu_pkg::STORE_AW'(iss.col)),
    .wdata (iss.pix),
    .re    (iss_valid),
    .raddr (rgbu_pkg::STORE_AW'(iss.col)),
    .rdata (rd_data)
  );

  rgbu_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .iss_valid    (iss_valid),
    .iss          (iss),
    .rd_data      (rd_data),
    .col_take     (col_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .pixel_out    (pixel_out),
    .last_of_item (last_of_item)
  );

  // beats of one item leave back to back once the first is taken
  a_item_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_item |=> out_valid)
    else $error("gap inside the beats of one item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // a column issues only into a free emit stage
  a_issue_free: assert property (@(posedge clk) disable iff (rst)
    iss_valid |-> col_take)
    else $error("column issued while emit stage busy");

endmodule

@@ hw/rtl/rgbu_ram.sv @@
module rgbu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rgbu_feed.sv @@
module rgbu_feed (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rgbu_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rgbu_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgbu_pkg::PIX_W-1:0]  pixel_in,
  input  logic                        col_take,
  output logic                        iss_valid,
  output rgbu_pkg::col_issue_t        iss
);

  logic [rgbu_pkg::CFG_W-1:0] source_width;
  logic [rgbu_pkg::CFG_W-1:0] source_height;
  logic [rgbu_pkg::COL_W-1:0] column_count;
  logic [rgbu_pkg::ROW_W-1:0] row_count;
  logic [rgbu_pkg::PIX_W-1:0] previous_pixel;

  logic                       a_valid;
  logic [rgbu_pkg::PIX_W-1:0] a_cur;
  logic [rgbu_pkg::PIX_W-1:0] a_mid;
  logic [rgbu_pkg::COL_W-1:0] a_x;
  logic [rgbu_pkg::ROW_W-1:0] a_y;
  logic                       a_first_row;
  logic                       a_last_row;
  logic                       a_last_col;
  rgbu_pkg::kind_t            a_kind;

  logic [rgbu_pkg::COL_W:0]   w_eff;
  logic [rgbu_pkg::ROW_W:0]   h_eff;
  logic                       last_col;
  logic                       last_row;
  logic                       accept;
  logic                       cfg_hit;
  logic [rgbu_pkg::ADDR_W-1:0] col_base;

  always_comb begin
    if (source_width == '0) begin
      w_eff = (rgbu_pkg::COL_W+1)'(1);
    end else if (32'(source_width) > rgbu_pkg::MAX_WIDTH) begin
      w_eff = (rgbu_pkg::COL_W+1)'(rgbu_pkg::MAX_WIDTH);
    end else begin
      w_eff = (rgbu_pkg::COL_W+1)'(source_width);
    end
    if (source_height == '0) begin
      h_eff = (rgbu_pkg::ROW_W+1)'(1);
    end else if (32'(source_height) > rgbu_pkg::MAX_HEIGHT) begin
      h_eff = (rgbu_pkg::ROW_W+1)'(rgbu_pkg::MAX_HEIGHT);
    end else begin
      h_eff = (rgbu_pkg::ROW_W+1)'(source_height);
    end
  end

  assign last_col = ({1'b0, column_count} + (rgbu_pkg::COL_W+1)'(1)) == w_eff;
  assign last_row = ({1'b0, row_count} + (rgbu_pkg::ROW_W+1)'(1)) == h_eff;

  // column issue
  assign col_base = {a_x, 1'b0};
  always_comb begin
    iss.row       = a_y;
    iss.first_row = a_first_row;
    iss.last_row  = a_last_row;
    case (a_kind)
      rgbu_pkg::K_MID: begin
        iss.col       = col_base - rgbu_pkg::ADDR_W'(1);
        iss.pix       = a_mid;
        iss.item_last = 1'b0;
      end
      rgbu_pkg::K_EVEN: begin
        iss.col       = col_base;
        iss.pix       = a_cur;
        iss.item_last = !a_last_col;
      end
      rgbu_pkg::K_EDGE: begin
        iss.col       = col_base | rgbu_pkg::ADDR_W'(1);
        iss.pix       = a_cur;
        iss.item_last = 1'b1;
      end
      default: begin
        iss.col       = col_base;
        iss.pix       = a_cur;
        iss.item_last = 1'b1;
      end
    endcase
  end

  assign iss_valid = a_valid && col_take;
  assign in_ready  = !a_valid || (iss_valid && iss.item_last);
  assign accept    = in_valid && in_ready;
  assign cfg_hit   = cfg_write && (cfg_index == rgbu_pkg::REG_SOURCE_WIDTH ||
                                   cfg_index == rgbu_pkg::REG_SOURCE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width   <= rgbu_pkg::WIDTH_RESET;
      source_height  <= rgbu_pkg::HEIGHT_RESET;
      column_count   <= '0;
      row_count      <= '0;
      previous_pixel <= '0;
      a_valid        <= 1'b0;
      a_kind         <= rgbu_pkg::K_EVEN;
    end else begin
      if (cfg_write && cfg_index == rgbu_pkg::REG_SOURCE_WIDTH) begin
        source_width <= cfg_data;
      end
      if (cfg_write && cfg_index == rgbu_pkg::REG_SOURCE_HEIGHT) begin
        source_height <= cfg_data;
      end

      if (cfg_hit) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + rgbu_pkg::ROW_W'(1);
        end else begin
          column_count <= column_count + rgbu_pkg::COL_W'(1);
        end
      end

      if (accept) begin
        previous_pixel <= pixel_in;
        a_valid        <= 1'b1;
        a_kind         <= (column_count != '0) ? rgbu_pkg::K_MID : rgbu_pkg::K_EVEN;
      end else if (iss_valid) begin
        if (iss.item_last) begin
          a_valid <= 1'b0;
        end else if (a_kind == rgbu_pkg::K_MID) begin
          a_kind <= rgbu_pkg::K_EVEN;
        end else begin
          a_kind <= rgbu_pkg::K_EDGE;
        end
      end
    end
  end

  // item payload, held while the item issues its columns
  always_ff @(posedge clk) begin
    if (accept) begin
      a_cur       <= pixel_in;
      a_mid       <= rgbu_pkg::avg555(previous_pixel, pixel_in);
      a_x         <= column_count;
      a_y         <= row_count;
      a_first_row <= (row_count == '0);
      a_last_row  <= last_row;
      a_last_col  <= last_col;
    end
  end

endmodule

@@ hw/rtl/rgbu_emit.sv @@
module rgbu_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          iss_valid,
  input  rgbu_pkg::col_issue_t          iss,
  input  logic [rgbu_pkg::PIX_W-1:0]    rd_data,
  output logic                          col_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbu_pkg::COORD_W-1:0]  dest_x,
  output logic [rgbu_pkg::COORD_W-1:0]  dest_y,
  output logic [rgbu_pkg::PIX_W-1:0]    pixel_out,
  output logic                          last_of_item
);

  logic                        b_valid;
  logic [rgbu_pkg::ADDR_W-1:0] b_col;
  logic [rgbu_pkg::ROW_W-1:0]  b_row;
  logic [rgbu_pkg::PIX_W-1:0]  b_pix;
  logic                        b_last_row;
  logic                        b_item_last;
  rgbu_pkg::phase_t            b_phase;

  logic                        emit_now;
  logic                        final_row;
  logic [rgbu_pkg::ROW_W:0]    y_even;
  logic [rgbu_pkg::ROW_W:0]    y_sel;
  logic [rgbu_pkg::PIX_W-1:0]  pix_sel;

  assign emit_now  = b_valid && (!out_valid || out_ready);
  assign final_row = (b_phase == rgbu_pkg::PH_BELOW) ||
                     (b_phase == rgbu_pkg::PH_EVEN && !b_last_row);
  assign col_take  = !b_valid || (emit_now && final_row);
  assign y_even    = {b_row, 1'b0};

  // the stored row word is on rd_data from the cycle after the column issued
  always_comb begin
    case (b_phase)
      rgbu_pkg::PH_ABOVE: begin
        y_sel   = y_even - (rgbu_pkg::ROW_W+1)'(1);
        pix_sel = rgbu_pkg::avg555(rd_data, b_pix);
      end
      rgbu_pkg::PH_EVEN: begin
        y_sel   = y_even;
        pix_sel = b_pix;
      end
      rgbu_pkg::PH_BELOW: begin
        y_sel   = y_even | (rgbu_pkg::ROW_W+1)'(1);
        pix_sel = b_pix;
      end
      default: begin
        y_sel   = y_even;
        pix_sel = b_pix;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      b_phase   <= rgbu_pkg::PH_EVEN;
      out_valid <= 1'b0;
    end else begin
      if (iss_valid) begin
        b_valid <= 1'b1;
        b_phase <= iss.first_row ? rgbu_pkg::PH_EVEN : rgbu_pkg::PH_ABOVE;
      end else if (emit_now && final_row) begin
        b_valid <= 1'b0;
      end else if (emit_now) begin
        b_phase <= (b_phase == rgbu_pkg::PH_ABOVE) ? rgbu_pkg::PH_EVEN
                                                   : rgbu_pkg::PH_BELOW;
      end

      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid) begin
      b_col       <= iss.col;
      b_row       <= iss.row;
      b_pix       <= iss.pix;
      b_last_row  <= iss.last_row;
      b_item_last <= iss.item_last;
    end
    if (emit_now) begin
      dest_x       <= rgbu_pkg::COORD_W'(b_col);
      dest_y       <= rgbu_pkg::COORD_W'(y_sel);
      pixel_out    <= pix_sel;
      last_of_item <= b_item_last && final_row;
    end
  end

endmodule
